[rtl/sbsfp_pkg.sv]
// Shared types and constants for the servo bus status frame parser.
package sbsfp_pkg;

	localparam int MAX_BODY_BYTES  = 32;
	localparam int HELD_DATA_BYTES = 8;
	localparam int COUNT_W         = $clog2(MAX_BODY_BYTES + 1);
	localparam int DLEN_W          = 5;
	localparam int DATA_W          = 64;

	localparam logic [7:0] HDR_BYTE = 8'hFF;
	localparam logic [7:0] MIN_LEN  = 8'd2;
	localparam logic [7:0] MAX_LEN  = 8'(MAX_BODY_BYTES);
	localparam logic [7:0] DLEN_SAT = 8'd31;

	typedef enum logic [2:0] {
		PH_HDR1,
		PH_HDR2,
		PH_ID,
		PH_LEN,
		PH_BODY
	} phase_t;

	typedef struct packed {
		logic [7:0]        id;
		logic [7:0]        error;
		logic [DLEN_W-1:0] dlen;
		logic [DATA_W-1:0] data;
	} resp_t;

endpackage

[rtl/sbsfp_parse_core.sv]
// Frame state machine, running checksum and held data word.
module sbsfp_parse_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [7:0]         rx_byte,
	output logic               res_valid,
	output sbsfp_pkg::resp_t   res
);
	import sbsfp_pkg::*;

	phase_t                   phase_q, phase_d;
	logic [7:0]               id_q, id_d;
	logic [7:0]               len_q, len_d;
	logic [COUNT_W-1:0]       count_q, count_d;
	logic [7:0]               sum_q, sum_d;
	logic [7:0]               err_q, err_d;
	logic [DATA_W-1:0]        pend_q, pend_d;
	logic [DATA_W-1:0]        held_q, held_d;
	logic [COUNT_W:0]         count_inc;
	logic [7:0]               dlen;
	logic [DATA_W-1:0]        merged;

	assign count_inc = {1'b0, count_q} + 1'b1;
	assign dlen      = len_q - MIN_LEN;

	// lanes below the data length take the new bytes
	always_comb begin
		for (int i = 0; i < HELD_DATA_BYTES; i++) begin
			merged[8*i +: 8] = (8'(i) < dlen) ? pend_q[8*i +: 8] : held_q[8*i +: 8];
		end
		for (int i = HELD_DATA_BYTES; i < 8; i++) begin
			merged[8*i +: 8] = held_q[8*i +: 8];
		end
	end

	always_comb begin
		phase_d   = phase_q;
		id_d      = id_q;
		len_d     = len_q;
		count_d   = count_q;
		sum_d     = sum_q;
		err_d     = err_q;
		pend_d    = pend_q;
		held_d    = held_q;
		res_valid = 1'b0;
		res.id    = id_q;
		res.error = err_q;
		res.dlen  = (dlen > DLEN_SAT) ? DLEN_SAT[DLEN_W-1:0] : dlen[DLEN_W-1:0];
		res.data  = merged;
		case (phase_q)
			PH_HDR1: begin
				if (rx_byte == HDR_BYTE) phase_d = PH_HDR2;
			end
			PH_HDR2: begin
				phase_d = (rx_byte == HDR_BYTE) ? PH_ID : PH_HDR1;
			end
			PH_ID: begin
				id_d    = rx_byte;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d   = rx_byte;
				count_d = '0;
				sum_d   = id_q + rx_byte;
				phase_d = (rx_byte < MIN_LEN || rx_byte > MAX_LEN) ? PH_HDR1 : PH_BODY;
			end
			PH_BODY: begin
				count_d = count_inc[COUNT_W-1:0];
				if ({{(8 - COUNT_W){1'b0}}, count_inc} < {1'b0, len_q}) begin
					sum_d = sum_q + rx_byte;
					if (count_q == '0) begin
						err_d = rx_byte;
					end else begin
						for (int i = 0; i < HELD_DATA_BYTES; i++) begin
							if (count_q == COUNT_W'(i + 1)) pend_d[8*i +: 8] = rx_byte;
						end
					end
				end else begin
					phase_d = PH_HDR1;
					if (~sum_q == rx_byte) begin
						res_valid = 1'b1;
						held_d    = merged;
					end
				end
			end
			default: begin
				phase_d = PH_HDR1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR1;
			id_q    <= '0;
			len_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
			err_q   <= '0;
			pend_q  <= '0;
			held_q  <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			id_q    <= id_d;
			len_q   <= len_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			err_q   <= err_d;
			pend_q  <= pend_d;
			held_q  <= held_d;
		end
	end

endmodule

[rtl/sbsfp_out_reg.sv]
// Result register towards the response channel.
module sbsfp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sbsfp_pkg::resp_t res,
	input  logic             resp_stall,
	output logic             resp_valid,
	output sbsfp_pkg::resp_t resp_q
);
	import sbsfp_pkg::*;

	logic valid_q;

	assign resp_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!resp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) resp_q <= res;
	end

endmodule

[rtl/servo_bus_status_frame_parser.sv]
// Top level: servo bus status frame parser.
// Usage
//   Receive channel: rx_valid/rx_stall carry one bus byte (rx_byte) per request.
//   Response channel: resp_valid/resp_stall carry one parsed status frame per
//   request: resp_id, resp_error, data_length and the held 8-byte resp_data.
//   Frames FF FF id len body are hunted for byte by byte; a frame whose
//   checksum fails, or whose length is out of range, gives no response.
// Timing
//   A byte taken sits in the input register while it is parsed; its
//   response, if any, is then loaded into the result register, where it
//   waits to be accepted. One byte per cycle is sustained while the input
//   register is not held: the running checksum and byte-lane update are
//   the only logic between input and state registers.
// Stall
//   The input register only holds back while a frame-ending checksum byte
//   meets a full, stalled response register; bytes that give no response
//   keep flowing. rx_stall rises only while the input register is held.
// Reset
//   arst_n clears the parser to header hunting, zeroes the held data word and
//   empties both registers.
module servo_bus_status_frame_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rx_valid,
	output logic                           rx_stall,
	input  logic [7:0]                     rx_byte,
	output logic                           resp_valid,
	input  logic                           resp_stall,
	output logic [7:0]                     resp_id,
	output logic [7:0]                     resp_error,
	output logic [sbsfp_pkg::DLEN_W-1:0]   data_length,
	output logic [sbsfp_pkg::DATA_W-1:0]   resp_data
);
	import sbsfp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       go;
	logic       res_valid;
	resp_t      res;
	resp_t      resp_q;

	// byte moves on unless it makes a response that has nowhere to go
	assign go       = valid_s1 && (!res_valid || !resp_valid || !resp_stall);
	assign rx_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) byte_s1 <= rx_byte;
	end

	sbsfp_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	sbsfp_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (go && res_valid),
		.res        (res),
		.resp_stall (resp_stall),
		.resp_valid (resp_valid),
		.resp_q     (resp_q)
	);

	assign resp_id     = resp_q.id;
	assign resp_error  = resp_q.error;
	assign data_length = resp_q.dlen;
	assign resp_data   = resp_q.data;

endmodule

[tb/sbsfp_checker.sv]
// Response predictor and scoreboard for the servo bus status frame parser.
module sbsfp_checker
	import sbsfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	input  logic              rx_stall,
	input  logic [7:0]        rx_byte,
	input  logic              resp_valid,
	input  logic              resp_stall,
	input  logic [7:0]        resp_id,
	input  logic [7:0]        resp_error,
	input  logic [DLEN_W-1:0] data_length,
	input  logic [DATA_W-1:0] resp_data,
	output int unsigned       fail_count,
	output int unsigned       pending_count
);

	localparam int unsigned SHOW_MAX = 10;

	// shadow parser state
	phase_t            phase;
	logic [7:0]        cur_id;
	logic [7:0]        cur_len;
	logic [7:0]        body_idx;
	logic [7:0]        csum;
	logic [7:0]        err_byte;
	logic [DATA_W-1:0] data_acc;
	logic [DATA_W-1:0] held_word;

	resp_t             status_q[$];
	int unsigned       fails;

	// Advance the shadow parser by one byte; returns 1 with the response when a frame closes with a good checksum.
	function automatic bit parse_byte(input logic [7:0] b, output resp_t r);
		logic [7:0]        idx;
		logic [7:0]        dlen;
		int                lane;
		int unsigned       keep;
		logic [DATA_W-1:0] mask;
		r = '0;
		case (phase)
			PH_HDR1: begin
				if (b == HDR_BYTE)
					phase = PH_HDR2;
				return 1'b0;
			end
			PH_HDR2: begin
				phase = (b == HDR_BYTE) ? PH_ID : PH_HDR1;
				return 1'b0;
			end
			PH_ID: begin
				cur_id = b;
				phase  = PH_LEN;
				return 1'b0;
			end
			PH_LEN: begin
				cur_len  = b;
				body_idx = 8'd0;
				csum     = cur_id + b;
				phase    = (b < MIN_LEN || b > MAX_LEN) ? PH_HDR1 : PH_BODY;
				return 1'b0;
			end
			PH_BODY: begin
				idx      = body_idx;
				body_idx = body_idx + 8'd1;
				if (body_idx < cur_len) begin
					csum = csum + b;
					lane = int'(idx) - 1;
					if (idx == 8'd0)
						err_byte = b;
					else if (lane < HELD_DATA_BYTES)
						data_acc[8*lane +: 8] = b;
					return 1'b0;
				end
				// checksum byte
				phase = PH_HDR1;
				if (8'(~csum) != b)
					return 1'b0;
				dlen = cur_len - MIN_LEN;
				keep = (dlen > HELD_DATA_BYTES) ? HELD_DATA_BYTES : dlen;
				mask = (keep >= 8) ? '1 : ((64'd1 << (8*keep)) - 64'd1);
				held_word = (held_word & ~mask) | (data_acc & mask);
				r.id    = cur_id;
				r.error = err_byte;
				r.dlen  = (dlen > DLEN_SAT) ? DLEN_SAT[DLEN_W-1:0] : dlen[DLEN_W-1:0];
				r.data  = held_word;
				return 1'b1;
			end
			default: begin
				phase = PH_HDR1;
				return 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		resp_t want;
		resp_t got;
		bit    bad;
		if (!arst_n) begin
			phase     = PH_HDR1;
			cur_id    = '0;
			cur_len   = '0;
			body_idx  = '0;
			csum      = '0;
			err_byte  = '0;
			data_acc  = '0;
			held_word = '0;
			status_q.delete();
			fails          = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (rx_valid && !rx_stall) begin
				if (parse_byte(rx_byte, want))
					status_q.push_back(want);
			end
			if (resp_valid && !resp_stall) begin
				got.id    = resp_id;
				got.error = resp_error;
				got.dlen  = data_length;
				got.data  = resp_data;
				if (status_q.size() == 0) begin
					if (fails < SHOW_MAX)
						$display("unexpected response: id %02h error %02h dlen %0d data %016h",
							got.id, got.error, got.dlen, got.data);
					fails++;
				end else begin
					want = status_q.pop_front();
					bad  = (got.id != want.id) || (got.error != want.error) ||
						(got.dlen != want.dlen) || (got.data != want.data);
					if (bad) begin
						if (fails < SHOW_MAX)
							$display("response mismatch (exp/act): id %02h/%02h error %02h/%02h dlen %0d/%0d data %016h/%016h",
								want.id, got.id, want.error, got.error,
								want.dlen, got.dlen, want.data, got.data);
						fails++;
					end
				end
			end
			fail_count    <= fails;
			pending_count <= status_q.size();
		end
	end

endmodule

[tb/tb_top.sv]
// Stimulus, response back-pressure and verdict for the servo bus status frame parser.
module tb_top;
	import sbsfp_pkg::*;

	// Roughly how many bus bytes the run pushes in, directed frames included.
	localparam int unsigned BYTE_TARGET  = 750;
	// Cycles with no request moving on either channel before the run is abandoned.
	localparam int unsigned IDLE_LIMIT   = 2000;
	// Quiet cycles after the last response, to catch anything spurious.
	localparam int unsigned DRAIN_CYCLES = 8;

	// How the data bytes of a frame are filled.
	typedef enum int {
		FILL_RAND,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	logic              clk;
	logic              arst_n;
	logic              rx_valid;
	logic              rx_stall;
	logic [7:0]        rx_byte;
	logic              resp_valid;
	logic              resp_stall;
	logic [7:0]        resp_id;
	logic [7:0]        resp_error;
	logic [DLEN_W-1:0] data_length;
	logic [DATA_W-1:0] resp_data;

	int unsigned       fail_count;
	int unsigned       pending_count;
	int unsigned       sent;
	int unsigned       idle_run = 0;
	bit                burst;    // frame sent back to back, no gaps between bytes
	bit                tx_live;  // rx_valid left high after the last accepted byte

	servo_bus_status_frame_parser DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_byte     (rx_byte),
		.resp_valid  (resp_valid),
		.resp_stall  (resp_stall),
		.resp_id     (resp_id),
		.resp_error  (resp_error),
		.data_length (data_length),
		.resp_data   (resp_data)
	);

	// Scoreboard sits alongside the DUT and only watches the two channels.
	sbsfp_checker resp_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.rx_byte       (rx_byte),
		.resp_valid    (resp_valid),
		.resp_stall    (resp_stall),
		.resp_id       (resp_id),
		.resp_error    (resp_error),
		.data_length   (data_length),
		.resp_data     (resp_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Idle length: mostly none, often short, now and then a long one.
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// Offer one byte, hold it until it is taken, then maybe leave a gap.
	// rx_valid is only dropped when a gap follows, so back-to-back bytes never
	// see valid lowered and raised within the same step.
	task automatic put_byte(input logic [7:0] b);
		int unsigned g;
		rx_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (rx_stall);
		sent++;
		g       = burst ? 0 : gap_len();
		tx_live = (g == 0);
		if (g != 0) begin
			rx_valid <= 1'b0;
			rx_byte  <= 8'($urandom);
			repeat (g) @(posedge clk);
		end
	endtask

	// Build FF FF id len body. A length out of range stops after the length
	// byte, as the parser goes back to header hunting there. bad_sum flips
	// checksum bits; cut drops that many bytes off the tail (broken frame).
	task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
	                          input logic [7:0] err, input fill_t fill,
	                          input bit bad_sum, input int unsigned cut);
		logic [7:0] frame_q[$];
		logic [7:0] sum;
		logic [7:0] d;
		frame_q.push_back(HDR_BYTE);
		frame_q.push_back(HDR_BYTE);
		frame_q.push_back(id);
		frame_q.push_back(len);
		if (len >= MIN_LEN && len <= MAX_LEN) begin
			sum = id + len + err;
			frame_q.push_back(err);
			for (int i = 0; i < int'(len) - 2; i++) begin
				case (fill)
					FILL_ZERO: d = 8'h00;
					FILL_ONES: d = 8'hFF;
					default:   d = 8'($urandom);
				endcase
				sum = sum + d;
				frame_q.push_back(d);
			end
			d = ~sum;
			if (bad_sum)
				d = d ^ 8'($urandom_range(1, 255));
			frame_q.push_back(d);
		end
		repeat (cut) begin
			if (frame_q.size() > 1)
				void'(frame_q.pop_back());
		end
		foreach (frame_q[i])
			put_byte(frame_q[i]);
	endtask

	// Response back-pressure: calm stretches with no stall, and busy stretches
	// with random single-cycle stalls and the odd long hold.
	initial begin
		resp_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 3) == 0) begin
				resp_stall <= 1'b0;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end else begin
				repeat ($urandom_range(5, 40)) begin
					if ($urandom_range(0, 15) == 0) begin
						resp_stall <= 1'b1;
						repeat ($urandom_range(4, 24)) @(posedge clk);
					end else begin
						resp_stall <= ($urandom_range(0, 2) == 0);
						@(posedge clk);
					end
				end
			end
		end
	end

	// Watchdog: gives up when neither channel has moved a request for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && !rx_stall) || (resp_valid && !resp_stall))
				idle_run <= 0;
			else if (idle_run >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else
				idle_run <= idle_run + 1;
		end
	end

	initial begin
		int unsigned pick;
		logic [7:0]  rl;
		arst_n   <= 1'b0;
		rx_valid <= 1'b0;
		rx_byte  <= 8'h00;
		burst    = 1'b0;
		tx_live  = 1'b0;
		sent     = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed frames ----
		// shortest legal body: error byte and checksum only, all-zero fields
		send_frame(8'h00, MIN_LEN, 8'h00, FILL_ZERO, 1'b0, 0);
		// FF then a non-header byte: the second byte must not restart the header
		put_byte(HDR_BYTE);
		put_byte(8'h5A);
		send_frame(8'h01, 8'd3, 8'h80, FILL_RAND, 1'b0, 0);
		// id of FF (third FF in a row is the id), error FF, a full word of FF data
		send_frame(HDR_BYTE, 8'd10, 8'hFF, FILL_ONES, 1'b0, 0);
		// one data byte: only the lowest lane changes, the FF bytes above persist
		send_frame(8'h02, 8'd3, 8'h01, FILL_ZERO, 1'b0, 0);
		// bad checksum: dropped, held word untouched
		send_frame(8'h03, 8'd4, 8'h00, FILL_RAND, 1'b1, 0);
		// lengths out of range either side, and the all-ones length
		send_frame(8'h04, 8'd1, 8'h00, FILL_RAND, 1'b0, 0);
		send_frame(8'h05, 8'd0, 8'h00, FILL_RAND, 1'b0, 0);
		send_frame(8'h06, MAX_LEN + 8'd1, 8'h00, FILL_RAND, 1'b0, 0);
		send_frame(8'h07, 8'hFF, 8'h00, FILL_RAND, 1'b0, 0);
		// longest body: data beyond the held word only feeds the checksum
		send_frame(8'hFE, MAX_LEN, 8'h7F, FILL_RAND, 1'b0, 0);
		// a good frame after the long one, byte lanes checked once more
		send_frame(8'h08, 8'd6, 8'h20, FILL_RAND, 1'b0, 0);

		// ---- random traffic: mostly well-formed frames, some broken ones ----
		while (sent < BYTE_TARGET) begin
			burst = ($urandom_range(0, 4) == 0);
			pick  = $urandom_range(0, 99);
			rl    = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(MIN_LEN, MAX_LEN))
			                                    : 8'($urandom_range(MIN_LEN, 12));
			if (pick < 70)
				send_frame(8'($urandom), rl, 8'($urandom),
					($urandom_range(0, 9) == 0) ? FILL_ONES : FILL_RAND, 1'b0, 0);
			else if (pick < 80)
				send_frame(8'($urandom), rl, 8'($urandom), FILL_RAND, 1'b1, 0);
			else if (pick < 86)
				send_frame(8'($urandom),
					$urandom_range(0, 1) ? 8'($urandom_range(0, 1))
					                     : 8'($urandom_range(MAX_BODY_BYTES + 1, 255)),
					8'($urandom), FILL_RAND, 1'b0, 0);
			else if (pick < 92)
				// truncated frame: the next header gets swallowed as body bytes
				send_frame(8'($urandom), rl, 8'($urandom), FILL_RAND, 1'b0,
					$urandom_range(1, int'(rl) + 1));
			else
				repeat ($urandom_range(1, 4))
					put_byte(($urandom_range(0, 2) == 0) ? HDR_BYTE : 8'($urandom));
		end

		if (tx_live)
			rx_valid <= 1'b0;
		// wait for the last byte's expectation to land in the scoreboard
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
